>>> sv/idpp_pkg.sv
// Shared types and constants for the IR duration pattern player.
// No dependencies; imported by every module of the block.
package idpp_pkg;

  localparam int NUM_SLOTS   = 10;
  localparam int MAX_ENTRIES = 64;
  localparam int DEPTH       = NUM_SLOTS * MAX_ENTRIES;
  localparam int ADDR_W      = $clog2(DEPTH);
  localparam int POS_W       = $clog2(MAX_ENTRIES + 1);
  localparam int SLOT_W      = 4;
  localparam int IDX_W       = 6;
  localparam int DUR_W       = 16;
  localparam int TIME_W      = 17;
  localparam int PERIOD_W    = 8;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 8'd26;
  localparam logic [DUR_W-1:0]    END_MARK     = 16'hFFFF;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_START = 2'd1,
    OP_TICK  = 2'd2
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [SLOT_W-1:0]  slot;
    logic [IDX_W-1:0]   idx;
    logic [DUR_W-1:0]   dur;
  } item_t;

  typedef struct packed {
    logic              re;
    logic [ADDR_W-1:0] raddr;
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [DUR_W-1:0]  wdata;
  } mem_req_t;

  typedef struct packed {
    logic done;
    logic busy;
    logic env;
  } result_t;

endpackage

>>> sv/idpp_store.sv
// Command store: single-port-write, single-port-read synchronous memory.
// Depends on idpp_pkg for depth, widths and the request struct.
module idpp_store
  import idpp_pkg::*;
(
  input  logic             clk,
  input  mem_req_t         req,
  output logic [DUR_W-1:0] rdata
);

  logic [DUR_W-1:0] mem [DEPTH];
  logic [DUR_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata_r <= mem[req.raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> sv/idpp_ctrl.sv
// Playback control: issues store reads at acceptance, then updates the
// playback state with the read data. Depends on idpp_pkg.
module idpp_ctrl
  import idpp_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic [PERIOD_W-1:0] period,
  input  logic                acc_fire,
  input  item_t               acc_item,
  input  logic                ex_fire,
  input  item_t               ex_item,
  input  logic [DUR_W-1:0]    rdata,
  output mem_req_t            mem_req,
  output result_t             res
);

  logic [SLOT_W-1:0]        active_slot_r, active_slot_nxt;
  logic [POS_W-1:0]         entry_pos_r, entry_pos_nxt;
  logic signed [TIME_W-1:0] time_left_r, time_left_nxt;
  logic                     envelope_r, envelope_nxt;
  logic                     playing_r, playing_nxt;

  logic [POS_W-1:0]         pos_inc;
  logic signed [TIME_W-1:0] tl_sub;
  logic signed [TIME_W-1:0] per_ext;
  logic                     env_out;
  logic                     done;

  assign pos_inc = entry_pos_r + POS_W'(1);
  assign per_ext = TIME_W'($signed({1'b0, period}));
  assign tl_sub  = time_left_r - per_ext;

  // Read address is formed while the previous item has fully retired; the
  // write side comes from the item in the execute stage.
  always_comb begin
    mem_req.re    = 1'b0;
    mem_req.raddr = '0;
    case (acc_item.op)
      OP_START: begin
        mem_req.re    = acc_fire && (int'(acc_item.slot) < NUM_SLOTS);
        mem_req.raddr = ADDR_W'(acc_item.slot) * ADDR_W'(MAX_ENTRIES);
      end
      OP_TICK: begin
        mem_req.re    = acc_fire && playing_r && (int'(pos_inc) < MAX_ENTRIES);
        mem_req.raddr = ADDR_W'(active_slot_r) * ADDR_W'(MAX_ENTRIES) + ADDR_W'(pos_inc);
      end
      default: begin
        mem_req.re    = 1'b0;
        mem_req.raddr = '0;
      end
    endcase
    mem_req.we    = ex_fire && (ex_item.op == OP_WRITE) &&
                    (int'(ex_item.slot) < NUM_SLOTS) && (int'(ex_item.idx) < MAX_ENTRIES);
    mem_req.waddr = ADDR_W'(ex_item.slot) * ADDR_W'(MAX_ENTRIES) + ADDR_W'(ex_item.idx);
    mem_req.wdata = ex_item.dur;
  end

  always_comb begin
    active_slot_nxt = active_slot_r;
    entry_pos_nxt   = entry_pos_r;
    time_left_nxt   = time_left_r;
    envelope_nxt    = envelope_r;
    playing_nxt     = playing_r;
    env_out         = 1'b0;
    done            = 1'b0;
    case (ex_item.op)
      OP_START: begin
        if (int'(ex_item.slot) < NUM_SLOTS) begin
          active_slot_nxt = ex_item.slot;
          entry_pos_nxt   = '0;
          envelope_nxt    = 1'b1;
          playing_nxt     = 1'b1;
          time_left_nxt   = TIME_W'($signed(rdata));
        end
      end
      OP_TICK: begin
        if (playing_r) begin
          env_out       = envelope_r;
          time_left_nxt = tl_sub;
          if (tl_sub[TIME_W-1] || (tl_sub == '0)) begin
            entry_pos_nxt = pos_inc;
            if ((int'(pos_inc) >= MAX_ENTRIES) || (rdata == END_MARK)) begin
              playing_nxt  = 1'b0;
              envelope_nxt = 1'b0;
              done         = 1'b1;
            end else begin
              time_left_nxt = TIME_W'($signed(rdata));
              envelope_nxt  = ~envelope_r;
            end
          end
        end
      end
      default: begin
        env_out = 1'b0;
      end
    endcase
  end

  assign res.env  = env_out;
  assign res.busy = playing_nxt;
  assign res.done = done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_slot_r <= '0;
      entry_pos_r   <= '0;
      time_left_r   <= '0;
      envelope_r    <= 1'b0;
      playing_r     <= 1'b0;
    end else if (ex_fire) begin
      active_slot_r <= active_slot_nxt;
      entry_pos_r   <= entry_pos_nxt;
      time_left_r   <= time_left_nxt;
      envelope_r    <= envelope_nxt;
      playing_r     <= playing_nxt;
    end
  end

endmodule

>>> sv/ir_duration_pattern_player_unit.sv
// Top level of the IR duration pattern player.
// Depends on idpp_pkg, idpp_store and idpp_ctrl.
//
// Usage:
//   Input channel (in_*): one transaction per item. in_tuser carries the
//   operation (write entry, start slot, carrier tick); in_tdata carries slot,
//   entry index and signed duration. Every item yields exactly one result.
//   Result channel (out_*): envelope_on, busy and done flags in out_tdata.
//   Configuration (cfg_*): cfg_we writes period_us from cfg_wdata; write
//   it only while no item is in flight.
// Timing:
//   An item's store read is issued as it is accepted, and the read data is
//   registered together with the item in the execute stage; the item then
//   executes from there into the output register. The execute stage holds a single
//   item, since a tick's read address depends on the entry position the
//   previous item leaves; so a new item is accepted only once the last one
//   has left the execute stage.
// Stall: a result waiting in the output register does not block the next
//   acceptance; that item waits in the execute stage, holding its store
//   read data, until the output register frees up.
// Reset: playback idles, period_us returns to 26, the output empties. The
//   store is not cleared; entries read before being written are undefined.
module ir_duration_pattern_player_unit
  import idpp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // slot[3:0], entry_index[9:4], duration[25:10], zero pad
  input  logic [1:0]  in_tuser,   // operation[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // envelope_on[0], busy_res[1], done_res[2], zero pad
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata
);

  logic [PERIOD_W-1:0] period_r;
  logic                ex_valid_r, ex_valid_nxt;
  item_t               ex_item_r;
  logic                out_valid_r, out_valid_nxt;
  result_t             out_res_r;

  logic                acc_fire;
  logic                ex_fire;
  item_t               acc_item;
  mem_req_t            mem_req;
  logic [DUR_W-1:0]    rdata;
  result_t             res;

  // Decode the incoming transaction into the item struct.
  assign acc_item.op   = op_t'(in_tuser);
  assign acc_item.slot = in_tdata[3:0];
  assign acc_item.idx  = in_tdata[9:4];
  assign acc_item.dur  = in_tdata[25:10];

  // Accept only with the execute stage empty: playback state is then final.
  assign in_tready = !ex_valid_r;
  assign acc_fire  = in_tvalid && in_tready;

  // Execute once the output register is free or being drained.
  assign ex_fire = ex_valid_r && (!out_valid_r || out_tready);

  always_comb begin
    ex_valid_nxt = ex_valid_r;
    if (acc_fire) begin
      ex_valid_nxt = 1'b1;
    end else if (ex_fire) begin
      ex_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ex_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r    <= PERIOD_RESET;
      ex_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        period_r <= cfg_wdata;
      end
      ex_valid_r  <= ex_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers: hold the item and the result without reset.
  always_ff @(posedge clk) begin
    if (acc_fire) begin
      ex_item_r <= acc_item;
    end
    if (ex_fire) begin
      out_res_r <= res;
    end
  end

  idpp_store u_store (
    .clk   (clk),
    .req   (mem_req),
    .rdata (rdata)
  );

  idpp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .period   (period_r),
    .acc_fire (acc_fire),
    .acc_item (acc_item),
    .ex_fire  (ex_fire),
    .ex_item  (ex_item_r),
    .rdata    (rdata),
    .mem_req  (mem_req),
    .res      (res)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, out_res_r.done, out_res_r.busy, out_res_r.env};

  // A finished playback never reports itself still busy.
  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[2] && out_tdata[1]))
    else $error("done and busy set together");

  // The envelope is only on during a tick of an active playback.
  a_env_implies_play: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[0]) |-> (out_tdata[1] || out_tdata[2]))
    else $error("envelope on outside playback");

  // Store reads happen at acceptance, writes at execution: never together.
  a_store_port_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_req.re && mem_req.we))
    else $error("store read and write in the same cycle");

  // A stalled execute stage keeps its item until it fires.
  a_ex_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (ex_valid_r && !ex_fire) |=> (ex_valid_r && $stable(ex_item_r)))
    else $error("execute stage lost its item");

endmodule

>>> tb/tb_ir_duration_pattern_player_unit.sv
`timescale 1ns / 100ps
// Self-checking testbench for ir_duration_pattern_player_unit: streams write, start and
// tick transactions and checks each result against a built-in model of the player.
// Depends on idpp_pkg and the player RTL; needs no files or arguments.
module tb_ir_duration_pattern_player_unit;
  import idpp_pkg::*;

  // Operation code 3 is undefined; the block must treat it as a no-op.
  localparam logic [1:0] OP_UNDEF = 2'd3;
  // Receiver hold-off used to fill the block and stall its input.
  localparam int HOLD_CYCLES = 200;
  // Cycles with work outstanding but no transaction before the run is abandoned.
  localparam int STALL_LIMIT = 3000;
  // Upper bound on ticks spent on one playback before moving on.
  localparam int TICK_CAP    = 400;

  typedef struct {
    logic [1:0]  op;
    logic [31:0] data;
    result_t     res;
  } player_item_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata   = '0;   // slot[3:0], entry_index[9:4], duration[25:10], zero pad
  logic [1:0]  in_tuser   = '0;   // operation[1:0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;         // envelope_on[0], busy_res[1], done_res[2], zero pad
  logic        cfg_we     = 1'b0;
  logic [7:0]  cfg_wdata  = '0;

  ir_duration_pattern_player_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  // 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Player model: command store, playback state and the period register.
  // It runs as items are queued; items are accepted in queue order, so each
  // prediction sees exactly the state the block will see.
  // ---------------------------------------------------------------------------
  logic [DUR_W-1:0]         cmd_mem     [DEPTH];
  bit                       cmd_written [DEPTH];
  logic [SLOT_W-1:0]        play_slot;
  logic [POS_W-1:0]         play_pos;
  logic signed [TIME_W-1:0] play_time;
  logic                     play_env;
  logic                     play_on;
  logic [PERIOD_W-1:0]      play_period;

  player_item_t item_q [$];             // transactions waiting for the driver
  result_t      envelope_expect_q [$];  // predicted results of accepted transactions
  result_t      inflight_res;
  result_t      want;
  player_item_t next_item;

  int items_queued   = 0;
  int results_seen   = 0;
  int fail_count     = 0;
  int send_gap_pct   = 0;
  int recv_stall_pct = 0;
  int hold_requests  = 0;
  int hold_seen      = 0;
  int hold_left      = 0;
  int stall_cycles   = 0;

  task automatic predict_player(input logic [1:0] op, input logic [SLOT_W-1:0] s,
                                input logic [IDX_W-1:0] e, input logic [DUR_W-1:0] d,
                                output result_t r);
    int               base;
    logic [DUR_W-1:0] next_dur;
    base = int'(s) * MAX_ENTRIES;
    r = '0;
    if (op == OP_WRITE) begin
      // Writes outside the store are dropped.
      if (s < NUM_SLOTS && e < MAX_ENTRIES) begin
        cmd_mem[base + int'(e)]     = d;
        cmd_written[base + int'(e)] = 1'b1;
      end
    end else if (op == OP_START) begin
      // Entry 0 loads as a time even when it is the end mark.
      if (s < NUM_SLOTS) begin
        play_slot = s;
        play_pos  = '0;
        play_env  = 1'b1;
        play_on   = 1'b1;
        play_time = {cmd_mem[base][DUR_W-1], cmd_mem[base]};
      end
    end else if (op == OP_TICK) begin
      if (play_on) begin
        r.env     = play_env;
        play_time = play_time - $signed({1'b0, play_period});
        if (play_time <= 0) begin
          play_pos = play_pos + 1'b1;
          next_dur = END_MARK;
          if (play_pos < MAX_ENTRIES)
            next_dur = cmd_mem[int'(play_slot) * MAX_ENTRIES + int'(play_pos)];
          if (next_dur == END_MARK) begin
            play_on  = 1'b0;
            play_env = 1'b0;
            r.done   = 1'b1;
          end else begin
            play_time = {next_dur[DUR_W-1], next_dur};
            play_env  = ~play_env;
          end
        end
      end
    end
    r.busy = play_on;
  endtask

  // True when playback from entry 'from' of slot s only ever reads written
  // entries before it stops at an end mark or runs past the last entry.
  function automatic bit chain_ok(input int s, input int from);
    int a;
    for (int k = from + 1; k < MAX_ENTRIES; k++) begin
      a = s * MAX_ENTRIES + k;
      if (!cmd_written[a]) return 1'b0;
      if (cmd_mem[a] == END_MARK) return 1'b1;
    end
    return 1'b1;
  endfunction

  function automatic bit start_ok(input int s);
    return s < NUM_SLOTS && cmd_written[s * MAX_ENTRIES] && chain_ok(s, 0);
  endfunction

  function automatic logic [DUR_W-1:0] pick_duration();
    // A rare long entry, only where the period keeps it to at most 256 ticks.
    if ($urandom_range(0, 99) == 0 && play_period >= 128)
      return 16'($urandom_range(16384, 32767));
    case ($urandom_range(0, 19))
      0:       return 16'd0;
      1:       return END_MARK;
      default: return 16'($urandom_range(1, 3 * int'(play_period)));
    endcase
  endfunction

  task automatic queue_item(input logic [1:0] op, input int s, input int e,
                            input logic [DUR_W-1:0] d);
    player_item_t it;
    it.op   = op;
    it.data = {6'b0, d, IDX_W'(e), SLOT_W'(s)};
    predict_player(op, SLOT_W'(s), IDX_W'(e), d, it.res);
    item_q.push_back(it);
    items_queued++;
  endtask

  // Ticks ignore their data fields, so fill them at random.
  task automatic queue_tick();
    queue_item(OP_TICK, $urandom_range(0, 15), $urandom_range(0, 63), 16'($urandom));
  endtask

  // Writes into the slot being played must not open a path to an entry that
  // was never written; turn such a write into an end mark instead.
  task automatic queue_write(input int s, input int e, input logic [DUR_W-1:0] d);
    int               a;
    logic [DUR_W-1:0] keep_dur;
    bit               keep_wr;
    logic [DUR_W-1:0] val;
    val = d;
    if (s < NUM_SLOTS && play_on && s == int'(play_slot)) begin
      a        = s * MAX_ENTRIES + e;
      keep_dur = cmd_mem[a];
      keep_wr  = cmd_written[a];
      cmd_mem[a]     = d;
      cmd_written[a] = 1'b1;
      if (!chain_ok(s, int'(play_pos))) val = END_MARK;
      cmd_mem[a]     = keep_dur;
      cmd_written[a] = keep_wr;
    end
    queue_item(OP_WRITE, s, e, val);
  endtask

  // One random transaction of any kind, out-of-range slots included.
  task automatic noise_item();
    int               s;
    logic [DUR_W-1:0] d;
    s = $urandom_range(0, 15);
    d = ($urandom_range(0, 7) == 0) ? END_MARK : 16'($urandom_range(0, 32767));
    case ($urandom_range(0, 3))
      0: queue_write(s, $urandom_range(0, 63), d);
      1: begin
        if (s >= NUM_SLOTS || start_ok(s))
          queue_item(OP_START, s, $urandom_range(0, 63), d);
        else
          queue_tick();
      end
      2: queue_tick();
      default: queue_item(OP_UNDEF, s, $urandom_range(0, 63), d);
    endcase
  endtask

  // Load an n-entry command into slot s (end mark first, then backwards so
  // every write lands in front of written entries), start it and tick it to
  // the end, with the odd stray transaction in between.
  task automatic run_program(input int s, input int n);
    int ticks;
    if (n < MAX_ENTRIES) queue_write(s, n, END_MARK);
    for (int k = n - 1; k >= 0; k--) queue_write(s, k, pick_duration());
    if (start_ok(s)) queue_item(OP_START, s, $urandom_range(0, 63), 16'($urandom));
    ticks = 0;
    while (play_on && ticks < TICK_CAP) begin
      if ($urandom_range(0, 11) == 0) begin
        noise_item();
      end else begin
        queue_tick();
        ticks++;
      end
    end
    repeat ($urandom_range(0, 2)) queue_tick();
  endtask

  task automatic run_random(input int target);
    while (items_queued < target) begin
      if ($urandom_range(0, 3) == 0)
        noise_item();
      else
        run_program($urandom_range(0, NUM_SLOTS - 1), $urandom_range(1, 6));
    end
  endtask

  // Block until every queued transaction has produced its result.
  task automatic wait_drained();
    while (results_seen < items_queued) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_period(input logic [PERIOD_W-1:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    play_period = v;
  endtask

  // ---------------------------------------------------------------------------
  // Driver: present queued transactions, hold each until accepted, and push its
  // prediction at the accepting edge. Gaps only open between transactions.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) envelope_expect_q.push_back(inflight_res);
      if (!in_tvalid || in_tready) begin
        if (item_q.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
          next_item    = item_q.pop_front();
          inflight_res = next_item.res;
          in_tvalid <= 1'b1;
          in_tuser  <= next_item.op;
          in_tdata  <= next_item.data;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: compare each result transaction with the oldest prediction, then
  // pick the next ready. A hold request drops ready for the receiver hold-off.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (envelope_expect_q.size() == 0) begin
          $error("result with nothing expected: out_tdata %h", out_tdata);
          fail_count++;
        end else begin
          want = envelope_expect_q.pop_front();
          if (out_tdata[0] !== want.env) begin
            $error("envelope_on: expected %0b, actual %0b", want.env, out_tdata[0]);
            fail_count++;
          end
          if (out_tdata[1] !== want.busy) begin
            $error("busy_res: expected %0b, actual %0b", want.busy, out_tdata[1]);
            fail_count++;
          end
          if (out_tdata[2] !== want.done) begin
            $error("done_res: expected %0b, actual %0b", want.done, out_tdata[2]);
            fail_count++;
          end
        end
      end
      if (hold_requests != hold_seen) begin
        hold_seen = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  // Watchdog: count cycles with results outstanding and no transaction on
  // either side.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        results_seen >= items_queued)
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("[ir_duration_pattern_player_unit] ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus sequence.
  // ---------------------------------------------------------------------------
  initial begin
    int run_slot;
    int ticks;

    play_slot   = '0;
    play_pos    = '0;
    play_time   = '0;
    play_env    = 1'b0;
    play_on     = 1'b0;
    play_period = PERIOD_RESET;

    send_gap_pct   = 34;
    recv_stall_pct = 57;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, reset period of 26 us.
    // Tick while idle: all-zero result.
    queue_item(OP_TICK, 0, 0, 16'd0);
    // Undefined operation with every data bit set.
    queue_item(OP_UNDEF, 15, 63, 16'hFFFF);
    // Start of a slot beyond the store: ignored.
    queue_item(OP_START, 15, 0, 16'd0);
    // Write beyond the store, then a write to the last entry of the last slot.
    queue_write(12, 7, 16'h7FFF);
    queue_write(NUM_SLOTS - 1, MAX_ENTRIES - 1, 16'h7FFF);
    // End mark at entry 0: first tick plays it, then hits the mark at entry 1.
    queue_write(0, 1, END_MARK);
    queue_write(0, 0, END_MARK);
    queue_item(OP_START, 0, 0, 16'd0);
    queue_tick();
    // Slot 1: 30 us, 0 us, end; rewrite entry 1 while playing, then restart
    // slot 0 over it.
    queue_write(1, 2, END_MARK);
    queue_write(1, 1, 16'd0);
    queue_write(1, 0, 16'd30);
    queue_item(OP_START, 1, 0, 16'd0);
    queue_tick();
    queue_write(1, 1, 16'd5);
    queue_tick();
    queue_item(OP_START, 0, 0, 16'd0);
    queue_tick();
    queue_tick();
    // Replay slot 1 to its end.
    queue_item(OP_START, 1, 0, 16'd0);
    while (play_on) queue_tick();
    wait_drained();

    // Longest period, sender gaps light, receiver stalls heavy.
    write_period(8'd255);
    run_random(items_queued + 140);
    wait_drained();

    // Shortest period, idling the other way round.
    send_gap_pct   = 57;
    recv_stall_pct = 34;
    write_period(8'd1);
    run_random(items_queued + 140);
    wait_drained();

    // Random period, no idling.
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    write_period(8'($urandom_range(2, 254)));
    // Hold the receiver off while a command streams in, so the block fills up.
    hold_requests++;
    run_program($urandom_range(0, NUM_SLOTS - 1), 4);
    // Pause the sender until every result is back.
    wait_drained();

    // Fill a whole slot without an end mark and play past the last entry;
    // every entry lasts exactly one tick.
    run_slot = $urandom_range(0, NUM_SLOTS - 1);
    for (int k = MAX_ENTRIES - 1; k >= 0; k--)
      queue_write(run_slot, k, 16'($urandom_range(1, int'(play_period))));
    queue_item(OP_START, run_slot, 0, 16'd0);
    ticks = 0;
    while (play_on && ticks < TICK_CAP) begin
      queue_tick();
      ticks++;
    end
    run_random(items_queued + 20);

    wait_drained();
    repeat (10) @(posedge clk);
    if (envelope_expect_q.size() != 0) begin
      $error("%0d predicted results never arrived", envelope_expect_q.size());
      fail_count++;
    end
    if (fail_count == 0)
      $display("[ir_duration_pattern_player_unit] OK");
    else
      $display("[ir_duration_pattern_player_unit] ERROR");
    $finish;
  end

endmodule
